// ===== rtl/xsr_pkg.sv =====
// shared types, constants and helper functions of the xorshift range generator
package xsr_pkg;

    localparam int DataWidth = 64;
    localparam int AddrWidth = 4;
    localparam int IterWidth = 7;

    // generator state after reset and output multiplier after reset
    localparam logic [DataWidth-1:0] StateAtReset = 64'h74a1eb62bf6b40f9;
    localparam logic [DataWidth-1:0] MultAtReset  = 64'd2685821657736338717;

    // register byte addresses
    localparam logic [AddrWidth-1:0] AddrOutputMult = 4'h0;

    // status codes
    localparam logic [1:0] StatusOk        = 2'd0;
    localparam logic [1:0] StatusZeroSeed  = 2'd1;
    localparam logic [1:0] StatusBadBounds = 2'd2;

    // requested action
    typedef enum logic [2:0] {
        ACT_BOOL  = 3'd0,
        ACT_RAW   = 3'd1,
        ACT_BELOW = 3'd2,
        ACT_RANGE = 3'd3,
        ACT_SEED  = 3'd4
    } action_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } fsm_state_t;

    // command to a serial unit
    typedef struct packed {
        logic       start;
        logic [1:0] width_sel;
    } unit_cmd_t;

    // status from a serial unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

    // number of result bits for a width code
    function automatic logic [IterWidth-1:0] width_bits(input logic [1:0] sel);
        width_bits = 7'd8 << sel;
    endfunction

    // mask of the result bits for a width code
    function automatic logic [DataWidth-1:0] width_mask(input logic [1:0] sel);
        logic [DataWidth-1:0] m;
        case (sel)
            2'd0: m = 64'h0000_0000_0000_00ff;
            2'd1: m = 64'h0000_0000_0000_ffff;
            2'd2: m = 64'h0000_0000_ffff_ffff;
            default: m = 64'hffff_ffff_ffff_ffff;
        endcase
        width_mask = m;
    endfunction

    // one xorshift step: left 21, arithmetic right 27, left 37
    function automatic logic [DataWidth-1:0] advance(input logic [DataWidth-1:0] s);
        logic [DataWidth-1:0] s1;
        logic [DataWidth-1:0] s2;
        s1 = s ^ (s << 21);
        s2 = s1 ^ {{27{s1[63]}}, s1[63:27]};
        advance = s2 ^ (s2 << 37);
    endfunction

endpackage

// ===== rtl/xsr_mul.sv =====
// bit-serial shift-and-add multiplier, product kept modulo two to the 64
module xsr_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  xsr_pkg::unit_cmd_t            cmd,
    input  logic [xsr_pkg::DataWidth-1:0] mcand_in,
    input  logic [xsr_pkg::DataWidth-1:0] mplier_in,
    output xsr_pkg::unit_sts_t            sts,
    output logic [xsr_pkg::DataWidth-1:0] product
);

    logic [xsr_pkg::DataWidth-1:0] acc_reg, acc_next;
    logic [xsr_pkg::DataWidth-1:0] mcand_reg, mcand_next;
    logic [xsr_pkg::DataWidth-1:0] mplier_reg, mplier_next;
    logic [xsr_pkg::IterWidth-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;

    // one multiplier bit per cycle, lowest first; only the low W bits are needed
    always_comb begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (cmd.start) begin
            acc_next    = '0;
            mcand_next  = mcand_in;
            mplier_next = mplier_in;
            cnt_next    = xsr_pkg::width_bits(cmd.width_sel);
            busy_next   = 1'b1;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign product  = acc_reg;

endmodule

// ===== rtl/xsr_div.sv =====
// bit-serial restoring divider returning the remainder only
module xsr_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  xsr_pkg::unit_cmd_t            cmd,
    input  logic [xsr_pkg::DataWidth-1:0] dividend_in,
    input  logic [xsr_pkg::DataWidth-1:0] divisor_in,
    output xsr_pkg::unit_sts_t            sts,
    output logic [xsr_pkg::DataWidth-1:0] remainder
);

    logic [xsr_pkg::DataWidth-1:0] rem_reg, rem_next;
    logic [xsr_pkg::DataWidth-1:0] dvd_reg, dvd_next;
    logic [xsr_pkg::DataWidth-1:0] dsr_reg, dsr_next;
    logic [xsr_pkg::IterWidth-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [xsr_pkg::DataWidth:0]   trial;
    logic [xsr_pkg::DataWidth:0]   diff;
    logic [xsr_pkg::DataWidth-1:0] dvd_aligned;

    // dividend top-aligned so that W steps cover its W bits
    always_comb begin
        case (cmd.width_sel)
            2'd0: dvd_aligned = {dividend_in[7:0], 56'd0};
            2'd1: dvd_aligned = {dividend_in[15:0], 48'd0};
            2'd2: dvd_aligned = {dividend_in[31:0], 32'd0};
            default: dvd_aligned = dividend_in;
        endcase
    end

    // one dividend bit per cycle: shift in, subtract divisor when it fits
    always_comb begin
        trial     = {rem_reg, dvd_reg[xsr_pkg::DataWidth-1]};
        diff      = trial - {1'b0, dsr_reg};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start) begin
            rem_next  = '0;
            dvd_next  = dvd_aligned;
            dsr_next  = divisor_in;
            cnt_next  = xsr_pkg::width_bits(cmd.width_sel);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = diff[xsr_pkg::DataWidth-1:0];
            end else begin
                rem_next = trial[xsr_pkg::DataWidth-1:0];
            end
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/xorshift_star_range_generator.sv =====
// xorshift generator with a multiplied output word: raw, boolean, bounded and ranged draws
//
// One transaction is worked on at a time. Seed loads, boolean draws,
// rejected bounds and unused actions go from the check state straight to
// the finish state; raw draws pass through the multiplier first, and
// bounded or ranged draws through the multiplier and then the divider.
// With W the selected width (8, 16, 32 or 64), the output word comes from
// a serial multiplier that takes one multiplier bit per cycle over W bits,
// and the range reduction from a serial restoring divider that takes one
// dividend bit per cycle over W bits. A finished result waits in the
// output register while the next transaction is accepted. The output
// multiplier is written through the register port at address 0.
module xorshift_star_range_generator (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // lower_bound [63:0], upper_bound [127:64], seed_value [191:128]
    input  logic [191:0]                    s_tdata,
    // action [2:0], width_select [4:3], signed_mode [5]
    input  logic [5:0]                      s_tuser,
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // value [63:0]
    output logic [63:0]                     m_tdata,
    // status [1:0]
    output logic [1:0]                      m_tuser,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [xsr_pkg::AddrWidth-1:0]   paddr,
    input  logic [xsr_pkg::DataWidth-1:0]   pwdata,
    output logic [xsr_pkg::DataWidth-1:0]   prdata,
    output logic                            pready
);

    xsr_pkg::fsm_state_t fsm_reg, fsm_next;

    logic [2:0]                    action_reg;
    logic [1:0]                    sel_reg;
    logic                          sgn_reg;
    logic [xsr_pkg::DataWidth-1:0] lower_reg;
    logic [xsr_pkg::DataWidth-1:0] upper_reg;
    logic [xsr_pkg::DataWidth-1:0] seed_reg;
    logic [xsr_pkg::DataWidth-1:0] span_reg;
    logic [xsr_pkg::DataWidth-1:0] gen_state_reg;
    logic [xsr_pkg::DataWidth-1:0] mult_reg;
    logic [xsr_pkg::DataWidth-1:0] res_value_reg;
    logic [1:0]                    res_status_reg;
    logic                          m_valid_reg;
    logic [xsr_pkg::DataWidth-1:0] m_data_reg;
    logic [1:0]                    m_user_reg;

    logic                          in_accept;
    logic                          cfg_write;
    logic [xsr_pkg::DataWidth-1:0] in_mask;
    logic [xsr_pkg::DataWidth-1:0] mask;
    logic [xsr_pkg::DataWidth-1:0] sign_bit;
    logic [xsr_pkg::DataWidth-1:0] cmp_upper;
    logic [xsr_pkg::DataWidth-1:0] cmp_lower;
    logic                          bad_bounds;
    logic [xsr_pkg::DataWidth-1:0] span_calc;
    logic [xsr_pkg::DataWidth-1:0] adv_state;
    logic [xsr_pkg::DataWidth-1:0] raw_word;
    logic [xsr_pkg::DataWidth-1:0] range_value;
    logic [xsr_pkg::DataWidth-1:0] mul_product;
    logic [xsr_pkg::DataWidth-1:0] div_rem;

    xsr_pkg::unit_cmd_t mul_cmd, div_cmd;
    xsr_pkg::unit_sts_t mul_sts, div_sts;

    // sequencer outputs
    logic                          adv_en;
    logic                          seed_en;
    logic                          span_en;
    logic                          res_load;
    logic [xsr_pkg::DataWidth-1:0] res_value_d;
    logic [1:0]                    res_status_d;
    logic                          out_load;

    assign in_accept = s_tvalid && s_tready;
    assign cfg_write = psel && penable && pwrite && pready;

    // bound checks, span, next generator state and draw values for the held transaction
    always_comb begin
        in_mask   = xsr_pkg::width_mask(s_tuser[4:3]);
        mask      = xsr_pkg::width_mask(sel_reg);
        sign_bit  = {1'b0, mask[xsr_pkg::DataWidth-1:1]} + 64'd1;
        cmp_upper = sgn_reg ? (upper_reg ^ sign_bit) : upper_reg;
        cmp_lower = sgn_reg ? (lower_reg ^ sign_bit) : lower_reg;
        if (action_reg == xsr_pkg::ACT_BELOW) begin
            bad_bounds = (upper_reg == '0) || (sgn_reg && ((upper_reg & sign_bit) != '0));
            span_calc  = upper_reg;
        end else begin
            bad_bounds = cmp_upper <= cmp_lower;
            span_calc  = (upper_reg - lower_reg) & mask;
        end
        adv_state = xsr_pkg::advance(gen_state_reg);
        raw_word  = mul_product & mask & ~(sgn_reg ? sign_bit : '0);
        if (action_reg == xsr_pkg::ACT_BELOW) begin
            range_value = div_rem & mask;
        end else begin
            range_value = (lower_reg + div_rem) & mask;
        end
    end

    // next state
    always_comb begin
        fsm_next = fsm_reg;
        case (fsm_reg)
            xsr_pkg::ST_IDLE: begin
                if (in_accept) begin
                    fsm_next = xsr_pkg::ST_CHECK;
                end
            end
            xsr_pkg::ST_CHECK: begin
                case (action_reg)
                    xsr_pkg::ACT_RAW: fsm_next = xsr_pkg::ST_MUL;
                    xsr_pkg::ACT_BELOW, xsr_pkg::ACT_RANGE: begin
                        fsm_next = bad_bounds ? xsr_pkg::ST_FIN : xsr_pkg::ST_MUL;
                    end
                    default: fsm_next = xsr_pkg::ST_FIN;
                endcase
            end
            xsr_pkg::ST_MUL: begin
                if (mul_sts.done) begin
                    fsm_next = (action_reg == xsr_pkg::ACT_RAW) ?
                               xsr_pkg::ST_FIN : xsr_pkg::ST_DIV;
                end
            end
            xsr_pkg::ST_DIV: begin
                if (div_sts.done) begin
                    fsm_next = xsr_pkg::ST_FIN;
                end
            end
            xsr_pkg::ST_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    fsm_next = xsr_pkg::ST_IDLE;
                end
            end
            default: fsm_next = xsr_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        adv_en            = 1'b0;
        seed_en           = 1'b0;
        span_en           = 1'b0;
        res_load          = 1'b0;
        res_value_d       = '0;
        res_status_d      = xsr_pkg::StatusOk;
        out_load          = 1'b0;
        mul_cmd.start     = 1'b0;
        mul_cmd.width_sel = sel_reg;
        div_cmd.start     = 1'b0;
        div_cmd.width_sel = sel_reg;
        s_tready          = 1'b0;
        case (fsm_reg)
            xsr_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            xsr_pkg::ST_CHECK: begin
                res_load = 1'b1;
                span_en  = 1'b1;
                case (action_reg)
                    xsr_pkg::ACT_BOOL: begin
                        adv_en      = 1'b1;
                        res_value_d = {63'd0, ~adv_state[0]};
                    end
                    xsr_pkg::ACT_RAW: begin
                        adv_en        = 1'b1;
                        mul_cmd.start = 1'b1;
                    end
                    xsr_pkg::ACT_BELOW, xsr_pkg::ACT_RANGE: begin
                        if (bad_bounds) begin
                            res_status_d = xsr_pkg::StatusBadBounds;
                        end else begin
                            adv_en        = 1'b1;
                            mul_cmd.start = 1'b1;
                        end
                    end
                    xsr_pkg::ACT_SEED: begin
                        if (seed_reg == '0) begin
                            res_status_d = xsr_pkg::StatusZeroSeed;
                        end else begin
                            seed_en = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            xsr_pkg::ST_MUL: begin
                if (mul_sts.done) begin
                    if (action_reg == xsr_pkg::ACT_RAW) begin
                        res_load    = 1'b1;
                        res_value_d = mul_product & mask;
                    end else begin
                        div_cmd.start = 1'b1;
                    end
                end
            end
            xsr_pkg::ST_DIV: begin
                if (div_sts.done) begin
                    res_load    = 1'b1;
                    res_value_d = range_value;
                end
            end
            xsr_pkg::ST_FIN: begin
                out_load = !m_valid_reg || m_tready;
            end
            default: ;
        endcase
    end

    // serial multiplier: state times output multiplier
    xsr_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (mul_cmd),
        .mcand_in  (mult_reg),
        .mplier_in (adv_state),
        .sts       (mul_sts),
        .product   (mul_product)
    );

    // serial divider: raw word modulo span
    xsr_div u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (div_cmd),
        .dividend_in (raw_word),
        .divisor_in  (span_reg),
        .sts         (div_sts),
        .remainder   (div_rem)
    );

    // control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg       <= xsr_pkg::ST_IDLE;
            m_valid_reg   <= 1'b0;
            gen_state_reg <= xsr_pkg::StateAtReset;
            mult_reg      <= xsr_pkg::MultAtReset;
        end else begin
            fsm_reg <= fsm_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (adv_en) begin
                gen_state_reg <= adv_state;
            end else if (seed_en) begin
                gen_state_reg <= seed_reg;
            end
            if (cfg_write && (paddr == xsr_pkg::AddrOutputMult)) begin
                mult_reg <= pwdata;
            end
        end
    end

    // transaction and result payload
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            action_reg <= s_tuser[2:0];
            sel_reg    <= s_tuser[4:3];
            sgn_reg    <= s_tuser[5];
            lower_reg  <= s_tdata[63:0] & in_mask;
            upper_reg  <= s_tdata[127:64] & in_mask;
            seed_reg   <= s_tdata[191:128];
        end
        if (span_en) begin
            span_reg <= span_calc;
        end
        if (res_load) begin
            res_value_reg  <= res_value_d;
            res_status_reg <= res_status_d;
        end
        if (out_load) begin
            m_data_reg <= res_value_reg;
            m_user_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // register read
    assign pready = 1'b1;
    assign prdata = (paddr == xsr_pkg::AddrOutputMult) ? mult_reg : '0;

    // checks
    a_state_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        gen_state_reg != '0)
        else $error("generator state became zero");

    a_accept_to_check: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> (fsm_reg == xsr_pkg::ST_CHECK))
        else $error("accepted transaction not checked next cycle");

    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_sts.busy && div_sts.busy))
        else $error("multiplier and divider busy together");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser != 2'd3))
        else $error("undefined status code");

endmodule

// ===== tb/xorshift_star_range_generator_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the xorshift star range generator with its own draw predictor
module xorshift_star_range_generator_tb;

    localparam int ClockHigh      = 6;
    localparam int ClockLow       = 6;
    localparam int ResetCycles    = 12;
    localparam int CycleLimit     = 1000000;
    localparam int SettleCycles   = 10;
    localparam int DrainCycles    = 200;
    localparam int LongHoldCycles = 500;
    localparam int NumPhases      = 5;

    // actions the block does nothing for
    localparam logic [2:0] ActFirstUnused = 3'd5;
    localparam logic [2:0] ActMidUnused   = 3'd6;
    localparam logic [2:0] ActLastUnused  = 3'd7;

    typedef struct {
        logic [2:0]  action;
        logic [1:0]  width_sel;
        logic        is_signed;
        logic [63:0] lower;
        logic [63:0] upper;
        logic [63:0] seed;
    } draw_request_t;

    typedef struct {
        logic [63:0] value;
        logic [1:0]  status;
    } draw_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // lower_bound [63:0], upper_bound [127:64], seed_value [191:128]
    logic [191:0] s_tdata = '0;
    // action [2:0], width_select [4:3], signed_mode [5]
    logic [5:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // value [63:0]
    logic [63:0]  m_tdata;
    // status [1:0]
    logic [1:0]   m_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [xsr_pkg::AddrWidth-1:0] paddr = '0;
    logic [xsr_pkg::DataWidth-1:0] pwdata = '0;
    logic [xsr_pkg::DataWidth-1:0] prdata;
    logic         pready;

    // predictor state: generator word and current output multiplier
    logic [63:0] gen_state = xsr_pkg::StateAtReset;
    logic [63:0] mult_setting = xsr_pkg::MultAtReset;

    draw_request_t pending_requests[$];
    draw_result_t  expected_draws[$];
    draw_request_t presented;
    draw_result_t  oldest_draw;

    int fail_count = 0;
    int results_seen = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    int holds_done = 0;
    int pattern_left = 0;
    int ready_pct = 100;

    xorshift_star_range_generator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    always begin
        #ClockHigh aclk = 1'b1;
        #ClockLow aclk = 1'b0;
    end

    // result bits of a width code
    function automatic logic [63:0] lane_mask(input logic [1:0] sel);
        lane_mask = ~64'd0 >> (7'd64 - (7'd8 << sel));
    endfunction

    // xorshift update: left 21, sign-filling right 27, left 37
    function automatic logic [63:0] xorshift_step(input logic [63:0] s);
        logic [63:0]        t;
        logic signed [63:0] arith;
        t = s ^ (s << 21);
        arith = t;
        arith = arith >>> 27;
        t = t ^ arith;
        xorshift_step = t ^ (t << 37);
    endfunction

    // expected result of one accepted request, advancing the predicted state
    function automatic draw_result_t predict_draw(input draw_request_t rq);
        logic [63:0]  mask;
        logic [63:0]  sign_bit;
        logic [63:0]  flip;
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [63:0]  span;
        logic [63:0]  word;
        draw_result_t res;
        mask = lane_mask(rq.width_sel);
        sign_bit = (mask >> 1) + 64'd1;
        flip = rq.is_signed ? sign_bit : 64'd0;
        lo = rq.lower & mask;
        hi = rq.upper & mask;
        span = '0;
        res.value = '0;
        res.status = xsr_pkg::StatusOk;
        case (rq.action)
            xsr_pkg::ACT_BOOL: begin
                gen_state = xorshift_step(gen_state);
                res.value = {63'd0, ~gen_state[0]};
            end
            xsr_pkg::ACT_RAW: begin
                gen_state = xorshift_step(gen_state);
                res.value = (gen_state * mult_setting) & mask;
            end
            xsr_pkg::ACT_BELOW, xsr_pkg::ACT_RANGE: begin
                if (rq.action == xsr_pkg::ACT_BELOW) begin
                    if (hi == 64'd0 || (hi & flip) != 64'd0) begin
                        res.status = xsr_pkg::StatusBadBounds;
                    end else begin
                        span = hi;
                        lo = '0;
                    end
                end else if ((hi ^ flip) <= (lo ^ flip)) begin
                    res.status = xsr_pkg::StatusBadBounds;
                end else begin
                    span = (hi - lo) & mask;
                end
                // rejected bounds leave the state alone
                if (res.status == xsr_pkg::StatusOk) begin
                    gen_state = xorshift_step(gen_state);
                    word = (gen_state * mult_setting) & mask & ~flip;
                    res.value = (lo + word % span) & mask;
                end
            end
            xsr_pkg::ACT_SEED: begin
                if (rq.seed == 64'd0) begin
                    res.status = xsr_pkg::StatusZeroSeed;
                end else begin
                    gen_state = rq.seed;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic logic [63:0] rand_word();
        rand_word = {$urandom, $urandom};
    endfunction

    // bound pattern, biased to the edges of the selected width
    function automatic logic [63:0] pick_bound(input logic [1:0] sel);
        logic [63:0] sb;
        sb = (lane_mask(sel) >> 1) + 64'd1;
        case ($urandom_range(0, 7))
            0: pick_bound = 64'd0;
            1: pick_bound = ~64'd0;
            2: pick_bound = sb;
            3: pick_bound = sb - 64'd1;
            4: pick_bound = 64'($urandom_range(0, 15));
            default: pick_bound = rand_word();
        endcase
    endfunction

    task automatic add_request(input logic [2:0] act, input logic [1:0] sel,
                               input logic sgn, input logic [63:0] lo,
                               input logic [63:0] hi, input logic [63:0] sd);
        draw_request_t rq;
        rq.action = act;
        rq.width_sel = sel;
        rq.is_signed = sgn;
        rq.lower = lo;
        rq.upper = hi;
        rq.seed = sd;
        pending_requests.push_back(rq);
    endtask

    task automatic add_random_request();
        draw_request_t rq;
        int            pick;
        logic [63:0]   m;
        logic [63:0]   flip;
        logic [63:0]   tmp;
        pick = $urandom_range(0, 99);
        rq.width_sel = 2'($urandom_range(0, 3));
        rq.is_signed = 1'($urandom_range(0, 1));
        rq.lower = pick_bound(rq.width_sel);
        rq.upper = pick_bound(rq.width_sel);
        rq.seed = ($urandom_range(0, 9) == 0) ? 64'd0 : rand_word();
        if (pick < 10) begin
            rq.action = xsr_pkg::ACT_BOOL;
        end else if (pick < 28) begin
            rq.action = xsr_pkg::ACT_RAW;
        end else if (pick < 55) begin
            rq.action = xsr_pkg::ACT_BELOW;
        end else if (pick < 90) begin
            rq.action = xsr_pkg::ACT_RANGE;
        end else if (pick < 97) begin
            rq.action = xsr_pkg::ACT_SEED;
        end else begin
            rq.action = 3'($urandom_range(ActFirstUnused, ActLastUnused));
        end
        // most bounded draws get well-formed bounds, the rest stay as drawn
        if ($urandom_range(0, 9) < 8) begin
            m = lane_mask(rq.width_sel);
            flip = rq.is_signed ? (m >> 1) + 64'd1 : 64'd0;
            if (rq.action == xsr_pkg::ACT_BELOW) begin
                rq.upper = rq.upper & ~flip;
                if ((rq.upper & m) == 64'd0) begin
                    rq.upper = rq.upper | 64'd1;
                end
            end else if (rq.action == xsr_pkg::ACT_RANGE) begin
                if (((rq.lower & m) ^ flip) > ((rq.upper & m) ^ flip)) begin
                    tmp = rq.lower;
                    rq.lower = rq.upper;
                    rq.upper = tmp;
                end
            end
        end
        pending_requests.push_back(rq);
    endtask

    // directed requests: field extremes, every action, each corner case
    task automatic load_directed();
        add_request(xsr_pkg::ACT_BOOL, 2'd0, 1'b0, '0, '0, '0);
        add_request(xsr_pkg::ACT_BOOL, 2'd3, 1'b1, ~64'd0, ~64'd0, ~64'd0);
        add_request(xsr_pkg::ACT_RAW, 2'd0, 1'b0, '0, '0, '0);
        add_request(xsr_pkg::ACT_RAW, 2'd1, 1'b1, '0, '0, '0);
        add_request(xsr_pkg::ACT_RAW, 2'd2, 1'b0, '0, '0, '0);
        add_request(xsr_pkg::ACT_RAW, 2'd3, 1'b0, '0, '0, '0);
        // zero bound, then bits only above the width
        add_request(xsr_pkg::ACT_BELOW, 2'd2, 1'b0, '0, 64'd0, '0);
        add_request(xsr_pkg::ACT_BELOW, 2'd0, 1'b0, '0, 64'hffff_ff00, '0);
        add_request(xsr_pkg::ACT_BELOW, 2'd0, 1'b0, '0, 64'd1, '0);
        add_request(xsr_pkg::ACT_BELOW, 2'd3, 1'b0, '0, ~64'd0, '0);
        // negative and largest positive signed bound
        add_request(xsr_pkg::ACT_BELOW, 2'd1, 1'b1, '0, 64'h8000, '0);
        add_request(xsr_pkg::ACT_BELOW, 2'd1, 1'b1, '0, 64'h7fff, '0);
        // empty and reversed ranges, plus valid full-width, signed and masked ones
        add_request(xsr_pkg::ACT_RANGE, 2'd0, 1'b0, 64'd5, 64'd5, '0);
        add_request(xsr_pkg::ACT_RANGE, 2'd2, 1'b0, 64'd9, 64'd3, '0);
        add_request(xsr_pkg::ACT_RANGE, 2'd3, 1'b0, 64'd0, ~64'd0, '0);
        add_request(xsr_pkg::ACT_RANGE, 2'd0, 1'b1, 64'h80, 64'h7f, '0);
        add_request(xsr_pkg::ACT_RANGE, 2'd0, 1'b1, 64'h10, 64'hf0, '0);
        add_request(xsr_pkg::ACT_RANGE, 2'd1, 1'b0, 64'habcd_0010, 64'h1234_0020, '0);
        // zero seed rejected, then extreme seeds
        add_request(xsr_pkg::ACT_SEED, 2'd0, 1'b0, '0, '0, 64'd0);
        add_request(xsr_pkg::ACT_SEED, 2'd3, 1'b1, '0, '0, ~64'd0);
        add_request(xsr_pkg::ACT_RAW, 2'd3, 1'b0, '0, '0, '0);
        add_request(xsr_pkg::ACT_SEED, 2'd0, 1'b0, '0, '0, 64'd1);
        add_request(xsr_pkg::ACT_BOOL, 2'd1, 1'b0, '0, '0, '0);
        add_request(ActFirstUnused, 2'd3, 1'b1, ~64'd0, ~64'd0, ~64'd0);
        add_request(ActMidUnused, 2'd1, 1'b0, rand_word(), rand_word(), rand_word());
        add_request(ActLastUnused, 2'd2, 1'b1, rand_word(), rand_word(), '0);
    endtask

    // wait until the block is idle with nothing outstanding
    task automatic wait_drained();
        while (pending_requests.size() != 0 || s_tvalid || expected_draws.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SettleCycles) @(posedge aclk);
    endtask

    // register write of the output multiplier, then read back
    task automatic write_multiplier(input logic [63:0] setting);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= xsr_pkg::AddrOutputMult;
        pwdata <= setting;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        mult_setting = setting;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== setting) begin
            $error("output_multiplier: expected %h, actual %h", setting, prdata);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // request driver: bursts of transactions with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_draws.push_back(predict_draw(presented));
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 || pending_requests.size() == 0) begin
                    if (gap_left > 0) begin
                        gap_left--;
                    end
                    s_tvalid <= 1'b0;
                end else begin
                    presented = pending_requests.pop_front();
                    s_tdata <= {presented.seed, presented.upper, presented.lower};
                    s_tuser <= {presented.is_signed, presented.width_sel, presented.action};
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // result receiver: stall pattern plus two long hold-offs
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (holds_done < 2 && results_seen >= (holds_done == 0 ? 60 : 600)) begin
            hold_left = LongHoldCycles;
            holds_done++;
            m_tready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(20, 80);
                case ($urandom_range(0, 2))
                    0: ready_pct = 100;
                    1: ready_pct = 70;
                    default: ready_pct = 25;
                endcase
            end else begin
                pattern_left--;
            end
            m_tready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    // result monitor: compare each transaction with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            if (expected_draws.size() == 0) begin
                $error("unexpected result: value %h, status %0d", m_tdata, m_tuser);
                fail_count++;
            end else begin
                oldest_draw = expected_draws.pop_front();
                if (m_tdata !== oldest_draw.value) begin
                    $error("value: expected %h, actual %h", oldest_draw.value, m_tdata);
                    fail_count++;
                end
                if (m_tuser !== oldest_draw.status) begin
                    $error("status: expected %0d, actual %0d", oldest_draw.status, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("xorshift_star_range_generator_tb: FAIL");
            $finish;
        end
    end

    // stimulus phases, one multiplier setting each
    initial begin
        logic [63:0] mult_plan [NumPhases];
        int          phase_items [NumPhases];
        mult_plan[0] = 64'd0;
        mult_plan[1] = ~64'd0;
        mult_plan[2] = 64'd1;
        mult_plan[3] = rand_word() | 64'd1;
        mult_plan[4] = xsr_pkg::MultAtReset;
        phase_items[0] = 150;
        phase_items[1] = 150;
        phase_items[2] = 150;
        phase_items[3] = 250;
        phase_items[4] = 300;
        repeat (ResetCycles) @(posedge aclk);
        aresetn <= 1'b1;
        load_directed();
        for (int i = 0; i < NumPhases; i++) begin
            wait_drained();
            write_multiplier(mult_plan[i]);
            repeat (phase_items[i]) add_random_request();
        end
        wait_drained();
        repeat (DrainCycles) @(posedge aclk);
        if (fail_count == 0 && expected_draws.size() == 0) begin
            $display("xorshift_star_range_generator_tb: PASS");
        end else begin
            $display("xorshift_star_range_generator_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== xorshift_star_range_generator.f =====
rtl/xsr_pkg.sv
rtl/xsr_mul.sv
rtl/xsr_div.sv
rtl/xorshift_star_range_generator.sv
tb/xorshift_star_range_generator_tb.sv
